/* src/cht_pkg.sv */
package cht_pkg;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_GET   = 2'd1,
        OP_ERASE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOME,
        ST_READ,
        ST_CHECK,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

/* src/cht_if.sv */
interface cht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] ip_addr;
    logic [15:0] port;
    logic [31:0] payload;
    modport source (output valid, op, ip_addr, port, payload, input ready);
    modport sink (input valid, op, ip_addr, port, payload, output ready);
endinterface

interface cht_rsp_if;
    logic        valid;
    logic        ready;
    logic        success;
    logic        was_new;
    logic [9:0]  slot_index;
    logic [31:0] payload_out;
    logic [10:0] entry_count;
    modport source (output valid, success, was_new, slot_index, payload_out, entry_count,
                    input ready);
    modport sink (input valid, success, was_new, slot_index, payload_out, entry_count,
                  output ready);
endinterface

/* src/cht_mod.sv */
// home slot: port modulo active count, one subtract per cycle (restoring divide)
module cht_mod
    import cht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [16:0] remainder
);
    logic [16:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [17:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[15]} - {1'b0, divisor};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
                rem_next = trial[16:0];
            else
                rem_next = {rem_reg[15:0], quo_reg[15]};
            quo_next = {quo_reg[14:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = busy_reg && (cnt_reg == 5'd1);
    assign remainder = (!trial[17]) ? trial[16:0] : {rem_reg[15:0], quo_reg[15]};
endmodule

/* src/connection_hash_table.sv */
// Connection table keyed by {ip_addr, port}, open addressing with a probe that
// alternates home+k and home-k around home = port mod active_slots, then runs
// on along the side that remains. Key, payload and valid bits live in
// synchronous RAMs with registered reads. After reset a clearing pass over all
// SLOTS entries (1024 by default) zeroes the valid map; ready stays low until it
// ends. One word is handled at a time: it is accepted, the home slot is formed
// with a serial remainder unit, then each probed slot is read from RAM and then
// compared, with a write-back on set/erase and a final step to post the result.
// A get or erase that misses probes all active slots. The result sits in an
// output register; a new word is accepted the cycle after it is taken.
module connection_hash_table
    import cht_pkg::*;
#(
    parameter int SLOTS        = 1024,
    parameter int PAYLOAD_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [10:0] cfg_wdata,
    cht_req_if.sink   req,
    cht_rsp_if.source rsp
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = IW + 1;
    localparam int KW = 48;

    // config register; the effective count is saturated to 1..SLOTS
    logic [10:0] active_reg;
    logic [16:0] act_eff;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 11'(SLOTS);
        else if (cfg_we)
            active_reg <= cfg_wdata;
    end
    always_comb
    begin
        if (active_reg == 11'd0)
            act_eff = 17'd1;
        else if (32'(active_reg) > SLOTS)
            act_eff = 17'(SLOTS);
        else
            act_eff = 17'(active_reg);
    end

    // storage
    logic [KW-1:0]           key_mem [SLOTS];
    logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];
    logic                    valid_mem [SLOTS];
    logic [KW-1:0]           key_rd;
    logic [PAYLOAD_BITS-1:0] pay_rd;
    logic [IW-1:0]           rd_addr;
    logic                    wr_en, wr_key;
    logic [IW-1:0]           wr_addr;
    logic [IW-1:0]           clr_reg, clr_next;   // clearing pass address

    // captured word
    state_t      state_reg, state_next;
    logic [1:0]  op_reg;
    logic [KW-1:0] key_reg;
    logic [PAYLOAD_BITS-1:0] pin_reg;
    logic [16:0] home_reg, k_reg, k_next;
    logic        side_reg, side_next;     // 0: up side, 1: down side
    logic [16:0] cur_reg, cur_next;
    logic [CW-1:0] count_reg, count_next;
    logic        valid_cur_reg;

    // result register
    logic        rv_reg, rv_next;
    logic        ok_reg, ok_next, new_reg, new_next;
    logic [9:0]  idx_reg, idx_next;
    logic [31:0] pout_reg, pout_next;

    logic        mod_start, mod_done;
    logic [16:0] mod_rem;

    cht_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req.port),
        .divisor   (act_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign req.ready = (state_reg == ST_IDLE) && !rv_reg;
    logic acc;
    assign acc = req.valid && req.ready;
    assign mod_start = acc;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            op_reg  <= req.op;
            key_reg <= {req.ip_addr, req.port};
            pin_reg <= PAYLOAD_BITS'(req.payload);
        end
        key_rd        <= key_mem[rd_addr];
        pay_rd        <= pay_mem[rd_addr];
        valid_cur_reg <= valid_mem[rd_addr];
        if (wr_en)
        begin
            pay_mem[wr_addr] <= pin_reg;
            if (wr_key)
                key_mem[wr_addr] <= key_reg;
        end
        // valid map: cleared one entry per cycle after reset, then set/erase
        if (state_reg == ST_CLEAR)
            valid_mem[clr_reg] <= 1'b0;
        else if (state_reg == ST_WRITE)
            valid_mem[cur_reg[IW-1:0]] <= (op_reg == OP_SET);
    end

    // next candidate in probe order after (k, side); last means none left
    logic [16:0] nk;
    logic        nside, nlast;
    logic [16:0] ncur;
    always_comb
    begin
        nk = k_reg; nside = side_reg; nlast = 1'b1; ncur = '0;
        // candidates in order: try down side of same k, then up of k+1, down of k+1
        if (!side_reg && k_reg != 17'd0 && home_reg >= k_reg)
        begin
            nside = 1'b1; nlast = 1'b0; ncur = home_reg - k_reg;
        end
        else
        begin
            nk = k_reg + 17'd1;
            if (nk < act_eff && home_reg + nk < act_eff)
            begin
                nside = 1'b0; nlast = 1'b0; ncur = home_reg + nk;
            end
            else if (nk < act_eff && home_reg >= nk)
            begin
                nside = 1'b1; nlast = 1'b0; ncur = home_reg - nk;
            end
        end
    end

    logic hit;
    always_comb
    begin
        hit = valid_cur_reg ? (key_rd == key_reg) : (op_reg == OP_SET);
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        k_next = k_reg; side_next = side_reg; cur_next = cur_reg;
        count_next = count_reg;
        rv_next = rv_reg; ok_next = ok_reg; new_next = new_reg;
        idx_next = idx_reg; pout_next = pout_reg;
        rd_addr = cur_reg[IW-1:0];
        wr_en = 1'b0; wr_key = 1'b0; wr_addr = cur_reg[IW-1:0];
        if (rv_reg && rsp.ready)
            rv_next = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(SLOTS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (acc)
                    state_next = ST_HOME;
            end
            ST_HOME:
            begin
                if (mod_done)
                begin
                    k_next = '0; side_next = 1'b0; cur_next = mod_rem;
                    if (op_reg == OP_NONE)
                    begin
                        ok_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (hit)
                begin
                    ok_next = 1'b1;
                    state_next = (op_reg == OP_GET) ? ST_DONE : ST_WRITE;
                end
                else if (nlast)
                begin
                    ok_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next = nk; side_next = nside; cur_next = ncur;
                    state_next = ST_READ;
                end
            end
            ST_WRITE:
            begin
                if (op_reg == OP_SET)
                begin
                    wr_en = 1'b1; wr_key = !valid_cur_reg;
                    if (!valid_cur_reg)
                        count_next = count_reg + CW'(1);
                end
                else if (count_reg != '0)
                    count_next = count_reg - CW'(1);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                rv_next   = 1'b1;
                new_next  = ok_reg && (op_reg == OP_SET) && !valid_cur_reg;
                idx_next  = ok_reg ? 10'(cur_reg) : 10'd0;
                pout_next = (ok_reg && op_reg == OP_GET) ? 32'(pay_rd) : 32'd0;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next; side_reg <= side_next; cur_reg <= cur_next;
        ok_reg <= ok_next; new_reg <= new_next; idx_reg <= idx_next;
        pout_reg <= pout_next;
        if (state_reg == ST_HOME && mod_done)
            home_reg <= mod_rem;
    end

    assign rsp.valid       = rv_reg;
    assign rsp.success     = ok_reg;
    assign rsp.was_new     = new_reg;
    assign rsp.slot_index  = idx_reg;
    assign rsp.payload_out = pout_reg;
    assign rsp.entry_count = 11'(count_reg);

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready) else $error("ready while busy");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= SLOTS) else $error("count overflow");
    a_new_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.was_new) |-> rsp.success) else $error("new without success");
    a_done_rv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> rv_reg) else $error("result lost");
endmodule

/* tb/connection_hash_table_tb.sv */
module connection_hash_table_tb
    import cht_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 1024;

    // one request word as queued for the driver
    typedef struct {
        op_t         op;
        logic [31:0] ip_addr;
        logic [15:0] port;
        logic [31:0] payload;
    } conn_req_t;

    // one result word as predicted
    typedef struct {
        logic        success;
        logic        was_new;
        logic [9:0]  slot_index;
        logic [31:0] payload_out;
        logic [10:0] entry_count;
    } conn_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_wdata;

    cht_req_if req_if ();
    cht_rsp_if rsp_if ();

    connection_hash_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if.sink),
        .rsp       (rsp_if.source)
    );

    // shadow copy of the table kept by the predictor
    logic        tbl_valid [SLOTS];
    logic [47:0] tbl_key [SLOTS];
    logic [31:0] tbl_payload [SLOTS];
    int unsigned tbl_count;
    int unsigned tbl_active;

    conn_req_t pending_reqs[$];
    conn_rsp_t expected_rsps[$];

    int  mismatches;
    bit  hold_rsp;       // forces a long receiver stall
    bit  req_taken;      // request word accepted at the last rising edge
    int  send_gap;
    int  take_gap;

    // keys already written, so gets and erases usually hit something
    logic [47:0] known_keys[$];

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // first matching slot in the two-sided probe order, -1 when none
    function automatic int find_slot(logic [47:0] key, int unsigned home, bit take_empty);
        int unsigned k;
        int s;
        for (k = 0; k < tbl_active; k++)
        begin
            if (home + k < tbl_active)
            begin
                s = home + k;
                if (tbl_valid[s] ? (tbl_key[s] == key) : take_empty)
                    return s;
            end
            if (k > 0 && home >= k)
            begin
                s = home - k;
                if (tbl_valid[s] ? (tbl_key[s] == key) : take_empty)
                    return s;
            end
        end
        return -1;
    endfunction

    // applies one accepted request to the shadow table and returns its result
    function automatic conn_rsp_t apply_request(conn_req_t r);
        conn_rsp_t   o;
        logic [47:0] key;
        int          s;
        key = {r.ip_addr, r.port};
        o = '{1'b0, 1'b0, 10'd0, 32'd0, 11'd0};
        s = -1;
        if (r.op != OP_NONE)
            s = find_slot(key, r.port % tbl_active, r.op == OP_SET);
        if (s >= 0)
        begin
            o.success = 1'b1;
            o.slot_index = s[9:0];
            case (r.op)
                OP_SET:
                begin
                    if (!tbl_valid[s])
                    begin
                        o.was_new = 1'b1;
                        tbl_valid[s] = 1'b1;
                        tbl_key[s] = key;
                        tbl_count++;
                    end
                    tbl_payload[s] = r.payload;
                end
                OP_GET:
                    o.payload_out = tbl_payload[s];
                OP_ERASE:
                begin
                    tbl_valid[s] = 1'b0;
                    if (tbl_count > 0)
                        tbl_count--;
                end
                default: ;
            endcase
        end
        o.entry_count = tbl_count[10:0];
        return o;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver: new words go out on the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.op <= OP_NONE;
            req_if.ip_addr <= '0;
            req_if.port <= '0;
            req_if.payload <= '0;
            send_gap <= 0;
        end
        else if (req_if.valid && !req_taken)
        begin
            // hold the word until it is taken
        end
        else if (req_if.valid && send_gap == 0 && pending_reqs.size() > 0)
        begin
            // word was taken at the last edge; next one goes straight out
            req_if.op <= pending_reqs[0].op;
            req_if.ip_addr <= pending_reqs[0].ip_addr;
            req_if.port <= pending_reqs[0].port;
            req_if.payload <= pending_reqs[0].payload;
            send_gap <= pick_gap();
        end
        else if (req_if.valid)
        begin
            req_if.valid <= 1'b0;
        end
        else if (send_gap > 0)
            send_gap <= send_gap - 1;
        else if (pending_reqs.size() > 0)
        begin
            req_if.valid <= 1'b1;
            req_if.op <= pending_reqs[0].op;
            req_if.ip_addr <= pending_reqs[0].ip_addr;
            req_if.port <= pending_reqs[0].port;
            req_if.payload <= pending_reqs[0].payload;
            send_gap <= pick_gap();
        end
    end

    // acceptance at the rising edge: pop the queue and predict
    always @(posedge clk)
    begin
        req_taken = rst_n && req_if.valid && req_if.ready;
        if (req_taken)
        begin
            conn_req_t r;
            r = pending_reqs.pop_front();
            expected_rsps.push_back(apply_request(r));
        end
    end

    // receiver ready, changed at the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            take_gap <= 0;
        end
        else if (hold_rsp)
            rsp_if.ready <= 1'b0;
        else if (take_gap > 0)
        begin
            rsp_if.ready <= 1'b0;
            take_gap <= take_gap - 1;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            take_gap <= pick_gap();
        end
    end

    // monitor: compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            conn_rsp_t e;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: slot %0d count %0d",
                             rsp_if.slot_index, rsp_if.entry_count);
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (rsp_if.success !== e.success || rsp_if.was_new !== e.was_new
                    || rsp_if.slot_index !== e.slot_index
                    || rsp_if.payload_out !== e.payload_out
                    || rsp_if.entry_count !== e.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp ok=%0b new=%0b slot=%0d pay=%h cnt=%0d",
                                 e.success, e.was_new, e.slot_index, e.payload_out,
                                 e.entry_count);
                        $display("          got ok=%0b new=%0b slot=%0d pay=%h cnt=%0d",
                                 rsp_if.success, rsp_if.was_new, rsp_if.slot_index,
                                 rsp_if.payload_out, rsp_if.entry_count);
                    end
                end
            end
        end
    end

    task automatic push_req(op_t op, logic [31:0] ip, logic [15:0] port, logic [31:0] pay);
        pending_reqs.push_back('{op, ip, port, pay});
        if (op == OP_SET)
            known_keys.push_back({ip, port});
    endtask

    // waits until every queued word has been answered
    task automatic drain();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // register write while the block is idle; shadow follows the same clamps
    task automatic write_active(logic [10:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        tbl_active = (val == 0) ? 1 : (val > SLOTS ? SLOTS : val);
    endtask

    // random word: mostly ops on remembered keys, some fresh keys and noise
    task automatic push_random(int unsigned port_span);
        int unsigned p;
        logic [47:0] key;
        op_t op;
        p = $urandom_range(0, 99);
        op = (p < 45) ? OP_SET : (p < 75) ? OP_GET : (p < 97) ? OP_ERASE : OP_NONE;
        if (known_keys.size() > 0 && $urandom_range(0, 99) < 60)
            key = known_keys[$urandom_range(0, known_keys.size() - 1)];
        else if ($urandom_range(0, 9) == 0)
            key = {$urandom(), 16'($urandom())};
        else
            key = {$urandom(), 16'($urandom_range(0, port_span))};
        push_req(op, key[47:16], key[15:0], $urandom());
    endtask

    initial
    begin
        int unsigned i;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_rsp = 1'b0;
        mismatches = 0;
        tbl_count = 0;
        tbl_active = SLOTS;
        for (i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, every op, duplicates, op 3
        push_req(OP_GET, 32'd0, 16'd0, 32'd0);
        push_req(OP_SET, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push_req(OP_SET, 32'd0, 16'd0, 32'd0);
        push_req(OP_SET, 32'hFFFF_FFFF, 16'hFFFF, 32'hA5A5_5A5A);
        push_req(OP_GET, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        push_req(OP_NONE, 32'h1234_5678, 16'h0000, 32'h1);
        push_req(OP_ERASE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        push_req(OP_ERASE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        push_req(OP_GET, 32'd0, 16'd0, 32'd0);
        drain();

        // tiny table: collisions, full-table set, duplicate in a hole
        write_active(11'd3);
        push_req(OP_SET, 32'd1, 16'd1, 32'h11);
        push_req(OP_SET, 32'd2, 16'd1, 32'h22);
        push_req(OP_SET, 32'd3, 16'd1, 32'h33);
        push_req(OP_SET, 32'd4, 16'd2, 32'h44);
        push_req(OP_ERASE, 32'd1, 16'd1, 32'd0);
        push_req(OP_SET, 32'd3, 16'd1, 32'h55);
        push_req(OP_GET, 32'd3, 16'd1, 32'd0);
        push_req(OP_ERASE, 32'd3, 16'd1, 32'd0);
        push_req(OP_GET, 32'd3, 16'd1, 32'd0);
        drain();

        // zero and oversized counts clamp to one and the table size
        write_active(11'd0);
        push_req(OP_SET, 32'd9, 16'd77, 32'h99);
        push_req(OP_GET, 32'd9, 16'd77, 32'd0);
        drain();
        write_active(11'd2047);
        push_req(OP_GET, 32'd9, 16'd77, 32'd0);
        drain();

        // random phases over several sizes; small ones keep scans short
        write_active(11'd1);
        for (i = 0; i < 40; i++)
            push_random(7);
        drain();
        write_active(11'd8);
        for (i = 0; i < 200; i++)
            push_random(31);
        for (i = 0; i < 20; i++)
            push_random(31);
        // long receiver stall while words keep coming
        fork
            begin
                hold_rsp = 1'b1;
                repeat (300) @(posedge clk);
                hold_rsp = 1'b0;
            end
        join_none
        drain();
        write_active(11'd37);
        for (i = 0; i < 200; i++)
            push_random(127);
        drain();
        write_active(11'd1024);
        for (i = 0; i < 100; i++)
            push_random(2047);
        drain();
        write_active(11'd5);
        for (i = 0; i < 20; i++)
            push_random(15);
        drain();

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial
    begin
        #8ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
src/cht_pkg.sv
src/cht_if.sv
src/cht_mod.sv
src/connection_hash_table.sv
tb/connection_hash_table_tb.sv
